// ----- rtl/wwoc_pkg.sv -----
// Shared types, constants and helpers for the whole-word occurrence counter.
package wwoc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAT_W      = 64;
  localparam int unsigned PLEN_W     = 5;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PAT_BYTES  = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [BYTE_W-1:0] COMMA_BYTE   = 8'h2C;
  localparam logic [BYTE_W-1:0] PERIOD_BYTE  = 8'h2E;
  localparam logic [BYTE_W-1:0] HYPHEN_BYTE  = 8'h2D;
  localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;

  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;
  localparam logic [PLEN_W-1:0] PLEN_RESET   = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2
  } cfg_idx_t;

  typedef logic [BYTE_W-1:0] byte_t;

  function automatic logic is_delim(input byte_t b);
    is_delim = (b == COMMA_BYTE) || (b == PERIOD_BYTE) ||
               (b == HYPHEN_BYTE) || (b == SPACE_BYTE);
  endfunction

endpackage

// ----- rtl/wwoc_ifs.sv -----
// Channel interfaces: text input, count result and configuration write.
interface wwoc_in_if;
  logic                      valid;
  logic                      ready;
  logic [wwoc_pkg::BYTE_W-1:0] text_byte;
  logic                      end_of_text;
  modport source (output valid, text_byte, end_of_text, input ready);
  modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface wwoc_out_if;
  logic                       valid;
  logic                       ready;
  logic [wwoc_pkg::CNT_W-1:0] word_count;
  logic                       counted_now;
  modport source (output valid, word_count, counted_now, input ready);
  modport sink   (input valid, word_count, counted_now, output ready);
endinterface

interface wwoc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wwoc_pkg::CFG_IDX_W-1:0] reg_index;
  logic [wwoc_pkg::PAT_W-1:0]     data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

// ----- rtl/whole_word_occurrence_counter_core.sv -----
// Whole-word occurrence counter: top level with input register, match logic and result register.
// Takes one text byte per word and returns one result word per input word, giving the
// running whole-word match count. Throughput is one word per cycle unless out_ch.ready holds
// the result; an accepted word passes the input register, then the result register. The pattern
// compare for every candidate length runs in parallel over a shift window of the line,
// so the state update in the match stage sets the rate. Configuration writes are always
// taken and must only be made while the block is idle.
module whole_word_occurrence_counter_core #(
  parameter int unsigned MAX_WORD = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  wwoc_in_if.sink           in_ch,
  wwoc_out_if.source        out_ch,
  wwoc_cfg_if.sink          cfg_ch
);

  localparam int unsigned LMAX  = (MAX_WORD < wwoc_pkg::PAT_BYTES) ? MAX_WORD
                                                                  : wwoc_pkg::PAT_BYTES;
  localparam int unsigned WIN_D = LMAX + 1;
  localparam int unsigned LW    = $clog2(LMAX + 1);
  localparam int unsigned PW    = $clog2(LMAX + 2);
  localparam int unsigned WIW   = $clog2(WIN_D);

  // configuration
  logic [wwoc_pkg::PAT_W-1:0]  pat_lo_r, pat_hi_r;
  logic [wwoc_pkg::PLEN_W-1:0] pat_len_r;

  // input register
  logic                s1_v_r;
  wwoc_pkg::byte_t     s1_byte_r;
  logic                s1_eot_r;

  // line state
  wwoc_pkg::byte_t     win_r [WIN_D];
  wwoc_pkg::byte_t     win_nxt [WIN_D];
  logic [PW-1:0]       lpos_r, lpos_nxt;
  logic [PW-1:0]       since_r, since_nxt;
  logic                pend_r, pend_nxt;
  logic [wwoc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // result register
  logic                out_v_r;
  logic [wwoc_pkg::CNT_W-1:0] word_count_r;
  logic                counted_r;

  logic                move, s1_fire, in_fire;
  logic                counted, line_end, hit, before_ok;
  logic [LW-1:0]       len_eff;
  logic [2*wwoc_pkg::PAT_W-1:0] pat_all;
  logic [LMAX:0]       match_at;
  logic                all_eq;

  assign move     = !out_v_r || out_ch.ready;
  assign s1_fire  = s1_v_r && move;
  assign in_ch.ready = !s1_v_r || move;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_v_r;
  assign out_ch.word_count  = word_count_r;
  assign out_ch.counted_now = counted_r;

  assign pat_all = {pat_hi_r, pat_lo_r};

  always_comb begin
    if (pat_len_r > wwoc_pkg::PLEN_W'(LMAX)) begin
      len_eff = LW'(LMAX);
    end else begin
      len_eff = pat_len_r[LW-1:0];
    end
  end

  // window after the shift of the current byte
  always_comb begin
    win_nxt[0] = s1_byte_r;
    for (int k = 1; k < WIN_D; k++) begin
      win_nxt[k] = win_r[k-1];
    end
  end

  // raw match for each candidate length
  always_comb begin
    match_at = '0;
    for (int l = 1; l <= LMAX; l++) begin
      all_eq = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win_nxt[l-1-i] != pat_all[8*i +: 8]) begin
          all_eq = 1'b0;
        end
      end
      match_at[l] = all_eq;
    end
  end

  always_comb begin
    counted   = pend_r && (s1_eot_r || s1_byte_r == wwoc_pkg::NEWLINE_BYTE ||
                           wwoc_pkg::is_delim(s1_byte_r));
    line_end  = s1_eot_r || s1_byte_r == wwoc_pkg::NEWLINE_BYTE;
    cnt_nxt   = (counted && cnt_r != wwoc_pkg::CNT_MAX) ? cnt_r + 1'b1 : cnt_r;
    lpos_nxt  = (lpos_r < PW'(WIN_D)) ? lpos_r + 1'b1 : lpos_r;
    since_nxt = (since_r < PW'(LMAX)) ? since_r + 1'b1 : since_r;
    hit       = (len_eff != '0) && (lpos_nxt >= PW'(len_eff)) &&
                (since_nxt >= PW'(len_eff)) && match_at[len_eff];
    before_ok = (lpos_nxt == PW'(len_eff)) ||
                wwoc_pkg::is_delim(win_nxt[WIW'(len_eff)]);
    pend_nxt  = 1'b0;
    if (line_end) begin
      lpos_nxt  = '0;
      since_nxt = PW'(LMAX);
    end else if (hit) begin
      since_nxt = '0;
      pend_nxt  = before_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      pat_len_r <= wwoc_pkg::PLEN_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.reg_index)
        wwoc_pkg::CFG_PATTERN_LOW:    pat_lo_r  <= cfg_ch.data;
        wwoc_pkg::CFG_PATTERN_HIGH:   pat_hi_r  <= cfg_ch.data;
        wwoc_pkg::CFG_PATTERN_LENGTH: pat_len_r <= cfg_ch.data[wwoc_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      lpos_r  <= '0;
      since_r <= PW'(LMAX);
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (in_fire) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (s1_fire) begin
        lpos_r  <= lpos_nxt;
        since_r <= since_nxt;
        pend_r  <= pend_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.text_byte;
      s1_eot_r  <= in_ch.end_of_text;
    end
    if (s1_fire) begin
      word_count_r <= cnt_nxt;
      counted_r    <= counted;
      if (!line_end) begin
        for (int k = 0; k < WIN_D; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end
    end
  end

  // a pending match was just found, so no byte has followed it yet
  a_pend_since: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> since_r == '0)
    else $error("pending match with nonzero byte distance");

  // the count moves by at most one per step
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && cnt_r != $past(cnt_r) |-> cnt_r == $past(cnt_r) + 1'b1)
    else $error("count jumped");

  // a counted result never reports a zero count
  a_counted_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && counted_r |-> word_count_r != '0)
    else $error("counted result with zero count");

  // a held result keeps the input register from advancing
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready && s1_v_r |=> s1_v_r && $stable(s1_byte_r))
    else $error("input stage advanced under back-pressure");

endmodule

// ----- sim/whole_word_occurrence_counter_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the whole-word occurrence counter core.
module whole_word_occurrence_counter_core_tb;

  localparam int unsigned WIN_DEPTH   = wwoc_pkg::PAT_BYTES + 1;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned DRAIN       = 8;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    wwoc_pkg::byte_t text_byte;
    logic            end_of_text;
  } char_t;

  typedef struct packed {
    logic [wwoc_pkg::CNT_W-1:0] word_count;
    logic                       counted_now;
  } tally_t;

  logic clk = 1'b0;
  logic rst_n;

  wwoc_in_if  in_ch();
  wwoc_out_if out_ch();
  wwoc_cfg_if cfg_ch();

  whole_word_occurrence_counter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  char_t       text_q[$];
  tally_t      tally_q[$];
  int unsigned err_count = 0;
  bit          calm_in  = 1'b0;
  bit          calm_out = 1'b0;

  // pattern as seen by the text generator
  logic [wwoc_pkg::PAT_W-1:0]  gen_lo, gen_hi;
  logic [wwoc_pkg::PLEN_W-1:0] gen_len;

  // counter model state
  logic [wwoc_pkg::PAT_W-1:0]  cur_lo, cur_hi;
  logic [wwoc_pkg::PLEN_W-1:0] cur_len;
  wwoc_pkg::byte_t             win [WIN_DEPTH];
  int unsigned                 line_pos;
  int unsigned                 since_match;
  logic                        pend;
  logic [wwoc_pkg::CNT_W-1:0]  occ;

  function automatic logic is_sep(input wwoc_pkg::byte_t b);
    return b == wwoc_pkg::COMMA_BYTE || b == wwoc_pkg::PERIOD_BYTE ||
           b == wwoc_pkg::HYPHEN_BYTE || b == wwoc_pkg::SPACE_BYTE;
  endfunction

  function automatic wwoc_pkg::byte_t sep_at(input int unsigned k);
    case (k)
      0:       return wwoc_pkg::COMMA_BYTE;
      1:       return wwoc_pkg::PERIOD_BYTE;
      2:       return wwoc_pkg::HYPHEN_BYTE;
      default: return wwoc_pkg::SPACE_BYTE;
    endcase
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic clear_line();
    for (int i = 0; i < WIN_DEPTH; i++) win[i] = '0;
    line_pos    = 0;
    since_match = wwoc_pkg::PAT_BYTES;
    pend        = 1'b0;
  endtask

  task automatic count_step(input wwoc_pkg::byte_t b, input logic eot, output tally_t res);
    logic [2*wwoc_pkg::PAT_W-1:0] pat;
    int unsigned                  len;
    logic                         counted;
    logic                         hit;
    pat     = {cur_hi, cur_lo};
    counted = 1'b0;
    if (pend) begin
      counted = eot || b == wwoc_pkg::NEWLINE_BYTE || is_sep(b);
      pend    = 1'b0;
    end
    if (counted && occ != wwoc_pkg::CNT_MAX) occ = occ + 1'b1;
    if (eot || b == wwoc_pkg::NEWLINE_BYTE) begin
      clear_line();
    end else begin
      len = (cur_len > wwoc_pkg::PAT_BYTES) ? wwoc_pkg::PAT_BYTES : cur_len;
      for (int i = WIN_DEPTH - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (line_pos < WIN_DEPTH) line_pos++;
      if (since_match < wwoc_pkg::PAT_BYTES) since_match++;
      if (len != 0 && line_pos >= len && since_match >= len) begin
        hit = 1'b1;
        for (int i = 0; i < len; i++)
          if (win[len-1-i] != pat[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          since_match = 0;
          if (line_pos == len || is_sep(win[len])) pend = 1'b1;
        end
      end
    end
    res.word_count  = occ;
    res.counted_now = counted;
  endtask

  // text driver; also snoops config writes and predicts each accepted word
  always @(posedge clk) begin : drive_text
    int unsigned gap_left;
    char_t       c;
    tally_t      t;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
      cur_lo   = '0;
      cur_hi   = '0;
      cur_len  = wwoc_pkg::PLEN_RESET;
      occ      = '0;
      clear_line();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          wwoc_pkg::CFG_PATTERN_LOW:    cur_lo  = cfg_ch.data;
          wwoc_pkg::CFG_PATTERN_HIGH:   cur_hi  = cfg_ch.data;
          wwoc_pkg::CFG_PATTERN_LENGTH: cur_len = cfg_ch.data[wwoc_pkg::PLEN_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        count_step(in_ch.text_byte, in_ch.end_of_text, t);
        tally_q.push_back(t);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (text_q.size() != 0) begin
          c = text_q.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.text_byte   <= c.text_byte;
          in_ch.end_of_text <= c.end_of_text;
          gap_left = pick_gap(calm_in);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : check_counts
    int unsigned hold_left;
    tally_t      e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (tally_q.size() == 0) begin
          $error("result word with no prediction: word_count %0d", out_ch.word_count);
          err_count++;
        end else begin
          e = tally_q.pop_front();
          if (out_ch.word_count !== e.word_count) begin
            $error("word_count: expected %0d, got %0d", e.word_count, out_ch.word_count);
            err_count++;
          end
          if (out_ch.counted_now !== e.counted_now) begin
            $error("counted_now: expected %0b, got %0b", e.counted_now, out_ch.counted_now);
            err_count++;
          end
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm_out && $urandom_range(0, 9) == 0) hold_left = pick_gap(1'b0);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic put(input wwoc_pkg::byte_t b, input logic eot);
    char_t c;
    c.text_byte   = b;
    c.end_of_text = eot;
    text_q.push_back(c);
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i], 1'b0);
  endtask

  function automatic logic [2*wwoc_pkg::PAT_W-1:0] rand_pattern();
    logic [2*wwoc_pkg::PAT_W-1:0] p;
    int unsigned                  r;
    for (int k = 0; k < 2 * wwoc_pkg::PAT_W / 8; k++) begin
      r = $urandom_range(0, 99);
      if (r < 80)      p[8*k +: 8] = wwoc_pkg::byte_t'(8'h61 + $urandom_range(0, 25));
      else if (r < 90) p[8*k +: 8] = wwoc_pkg::byte_t'($urandom_range(0, 255));
      else             p[8*k +: 8] = sep_at($urandom_range(0, 3));
    end
    return p;
  endfunction

  // mostly pattern words between delimiters, some near misses and noise
  task automatic add_text(input int unsigned n);
    logic [2*wwoc_pkg::PAT_W-1:0] pat;
    int unsigned                  cnt, r, plen, bad, k;
    pat  = {gen_hi, gen_lo};
    plen = (gen_len == 0) ? 3 :
           ((gen_len > wwoc_pkg::PAT_BYTES) ? wwoc_pkg::PAT_BYTES : gen_len);
    cnt  = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        for (k = 0; k < plen; k++) put(pat[8*k +: 8], 1'b0);
        cnt += plen;
      end else if (r < 45) begin
        bad = $urandom_range(0, plen - 1);
        for (k = 0; k < plen; k++)
          put((k == bad) ? pat[8*k +: 8] ^ (8'h01 << $urandom_range(0, 7)) : pat[8*k +: 8],
              1'b0);
        cnt += plen;
      end else if (r < 70) begin
        put(sep_at($urandom_range(0, 3)), 1'b0);
        cnt++;
      end else if (r < 80) begin
        k = $urandom_range(1, 5);
        cnt += k;
        repeat (k) put(wwoc_pkg::byte_t'(8'h61 + $urandom_range(0, 25)), 1'b0);
      end else if (r < 88) begin
        put(wwoc_pkg::NEWLINE_BYTE, 1'b0);
        cnt++;
      end else if (r < 95) begin
        put(wwoc_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
        cnt++;
      end else if (r < 98) begin
        put(wwoc_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
        cnt++;
      end else begin
        k = $urandom_range(1, plen);
        for (int j = 0; j < k; j++) put(pat[8*j +: 8], 1'b0);
        cnt += k;
      end
    end
  endtask

  // leaves the write channel valid; caller lowers it after the last write
  task automatic put_reg(input wwoc_pkg::cfg_idx_t idx,
                         input logic [wwoc_pkg::PAT_W-1:0] val);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic configure(input logic [wwoc_pkg::PAT_W-1:0] lo,
                           input logic [wwoc_pkg::PAT_W-1:0] hi,
                           input logic [wwoc_pkg::PAT_W-1:0] len_word);
    put_reg(wwoc_pkg::CFG_PATTERN_LOW, lo);
    put_reg(wwoc_pkg::CFG_PATTERN_HIGH, hi);
    put_reg(wwoc_pkg::CFG_PATTERN_LENGTH, len_word);
    cfg_ch.valid <= 1'b0;
    gen_lo  = lo;
    gen_hi  = hi;
    gen_len = len_word[wwoc_pkg::PLEN_W-1:0];
  endtask

  task automatic settle();
    @(posedge clk);
    while (text_q.size() != 0 || in_ch.valid || tally_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [2*wwoc_pkg::PAT_W-1:0] p;
    logic [wwoc_pkg::PAT_W-1:0]   lw;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.text_byte    = '0;
    in_ch.end_of_text  = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = wwoc_pkg::CFG_PATTERN_LOW;
    cfg_ch.data        = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // "cat": line start, drop on letter, letter before, newline and end of text
    configure(64'h0000_0000_0074_6163, {$urandom, $urandom}, 64'd3);
    put_str("cat.catx xcat cat\n");
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put_str(" cat");
    put(wwoc_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
    add_text(PHASE_ITEMS);
    settle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      p  = rand_pattern();
      lw = 64'($urandom_range(2, 8));
      case (ph)
        0: lw = 64'd1;
        1: lw = 64'd16;
        2: lw = 64'd0;
        3: begin
          lw = {$urandom, $urandom};
          lw[wwoc_pkg::PLEN_W-1:0] = 5'd17;
        end
        4: lw = 64'd31;
        5: begin
          p[23:16] = wwoc_pkg::NEWLINE_BYTE;
          lw = 64'd4;
        end
        6: begin
          p  = {{wwoc_pkg::PAT_W{1'b1}}, {wwoc_pkg::PAT_W{1'b0}}};
          lw = 64'd8;
        end
        7: begin
          p  = '1;
          lw = 64'd16;
        end
        8: begin
          p[23:0] = {8'h62, wwoc_pkg::HYPHEN_BYTE, 8'h61};
          lw = 64'd3;
        end
        default: ;
      endcase
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      configure(p[wwoc_pkg::PAT_W-1:0], p[2*wwoc_pkg::PAT_W-1:wwoc_pkg::PAT_W], lw);
      add_text(PHASE_ITEMS);
      settle();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
